### hw/rtl/bal_pkg.sv
// shared types and constants for the bounded array list
// no dependencies
`timescale 1ns / 1ps

package bal_pkg;

  localparam int DEPTH_DEFAULT = 256;
  localparam logic [8:0] CAPACITY_RESET = 9'd256;
  localparam logic [0:0] REG_CAPACITY = 1'b0;

  typedef enum logic [2:0] {
    OP_APPEND  = 3'd0,
    OP_INSERT  = 3'd1,
    OP_DELETE  = 3'd2,
    OP_SORT    = 3'd3,
    OP_REVERSE = 3'd4,
    OP_READ    = 3'd5,
    OP_NOP6    = 3'd6,
    OP_NOP7    = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS,
    S_INS_W,
    S_DEL0,
    S_DEL,
    S_READ,
    S_SORT_I,
    S_SORT_J,
    S_SORT_W,
    S_REV_A,
    S_REV_B,
    S_REV_C,
    S_DONE
  } state_t;

endpackage

### hw/rtl/bal_mem.sv
// entry storage: one write port, one read port, registered read data
// depends on bal_pkg for the default depth
`timescale 1ns / 1ps

module bal_mem #(
  parameter int DEPTH = bal_pkg::DEPTH_DEFAULT,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/bounded_array_list.sv
// bounded array list top level: sequencer, register port, result register
// depends on bal_pkg and bal_mem
//
// channel  dir  handshake           payload
// in       in   in_valid/in_stall   op, pos, value
// out      out  out_valid/out_stall status, data_out, count, empty_res, full_res
// cfg      in   apb psel/penable    capacity at byte address 0
//
// append and failed checks go straight to the result, read waits on registered read
// data, insert and delete shift the entries past pos one at a time, reverse swaps
// pairs, sort compares pairs in turn, all paced by the single memory read port
// synchronous reset clears the count and sets the capacity to 256, no clearing pass
// a stalled result holds in the output register, the next item waits
`timescale 1ns / 1ps

module bounded_array_list #(
  parameter int DEPTH = bal_pkg::DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         op,
  input  logic [8:0]         pos,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic signed [31:0] data_out,
  output logic [8:0]         count,
  output logic               empty_res,
  output logic               full_res
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  bal_pkg::state_t state, state_next;
  logic [8:0]  capacity, used, used_next;
  logic [8:0]  pos_r, pos_next, i, i_next, j, j_next;
  logic [31:0] val_r, val_next, hold, hold_next, data_r, data_next;
  bal_pkg::status_t st_r, st_next;
  logic [8:0]  eff_cap, rd_idx, wr_idx;
  logic        full, we;
  logic [31:0] wdata, rdata;
  logic        out_free;

  assign eff_cap = ({4'b0, capacity} > 13'(DEPTH)) ? 9'(DEPTH) : capacity;
  assign full = used >= eff_cap;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == bal_pkg::REG_CAPACITY) ? {23'b0, capacity} : 32'b0;
  assign in_stall = state != bal_pkg::S_IDLE;
  assign out_free = !out_valid || !out_stall;

  bal_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(wr_idx)),
    .wdata (wdata),
    .raddr (AW'(rd_idx)),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bal_pkg::S_IDLE;
      used      <= 9'd0;
      capacity  <= bal_pkg::CAPACITY_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      used  <= used_next;
      if (psel && penable && pwrite && paddr[2] == bal_pkg::REG_CAPACITY) begin
        capacity <= pwdata[8:0];
      end
      if (state == bal_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_next;
    val_r  <= val_next;
    i      <= i_next;
    j      <= j_next;
    hold   <= hold_next;
    data_r <= data_next;
    st_r   <= st_next;
    if (state == bal_pkg::S_DONE && out_free) begin
      status    <= st_r;
      data_out  <= data_r;
      count     <= used;
      empty_res <= used == 9'd0;
      full_res  <= full;
    end
  end

  always_comb begin
    state_next = state;
    used_next  = used;
    pos_next   = pos_r;
    val_next   = val_r;
    i_next     = i;
    j_next     = j;
    hold_next  = hold;
    data_next  = data_r;
    st_next    = st_r;
    rd_idx     = 9'd0;
    wr_idx     = 9'd0;
    we         = 1'b0;
    wdata      = rdata;
    unique case (state)
      bal_pkg::S_IDLE: begin
        if (in_valid) begin
          pos_next   = pos;
          val_next   = value;
          data_next  = 32'd0;
          st_next    = bal_pkg::ST_OK;
          state_next = bal_pkg::S_DONE;
          unique case (bal_pkg::op_t'(op))
            bal_pkg::OP_APPEND: begin
              if (full) begin
                st_next = bal_pkg::ST_FULL;
              end else begin
                we        = 1'b1;
                wr_idx    = used;
                wdata     = value;
                used_next = used + 9'd1;
              end
            end
            bal_pkg::OP_INSERT: begin
              if (full) begin
                st_next = bal_pkg::ST_FULL;
              end else if (pos == 9'd0 || {1'b0, pos} > {1'b0, used} + 10'd1) begin
                st_next = bal_pkg::ST_BADPOS;
              end else if (used >= pos) begin
                rd_idx     = used - 9'd1;
                i_next     = used;
                state_next = bal_pkg::S_INS;
              end else begin
                we        = 1'b1;
                wr_idx    = used;
                wdata     = value;
                used_next = used + 9'd1;
              end
            end
            bal_pkg::OP_DELETE, bal_pkg::OP_READ: begin
              if (used == 9'd0) begin
                st_next = bal_pkg::ST_EMPTY;
              end else if (pos == 9'd0 || pos > used) begin
                st_next = bal_pkg::ST_BADPOS;
              end else begin
                rd_idx     = pos - 9'd1;
                i_next     = pos - 9'd1;
                state_next = (bal_pkg::op_t'(op) == bal_pkg::OP_READ) ?
                             bal_pkg::S_READ : bal_pkg::S_DEL0;
              end
            end
            bal_pkg::OP_SORT: begin
              if (used == 9'd0) begin
                st_next = bal_pkg::ST_EMPTY;
              end else begin
                rd_idx     = 9'd0;
                i_next     = 9'd0;
                state_next = bal_pkg::S_SORT_I;
              end
            end
            bal_pkg::OP_REVERSE: begin
              if (used == 9'd0) begin
                st_next = bal_pkg::ST_EMPTY;
              end else if (used > 9'd1) begin
                rd_idx     = 9'd0;
                i_next     = 9'd0;
                j_next     = used - 9'd1;
                state_next = bal_pkg::S_REV_A;
              end
            end
            default: begin
            end
          endcase
        end
      end
      bal_pkg::S_INS: begin
        we     = 1'b1;
        wr_idx = i;
        wdata  = rdata;
        if (i > pos_r) begin
          rd_idx = i - 9'd2;
          i_next = i - 9'd1;
        end else begin
          state_next = bal_pkg::S_INS_W;
        end
      end
      bal_pkg::S_INS_W: begin
        we         = 1'b1;
        wr_idx     = pos_r - 9'd1;
        wdata      = val_r;
        used_next  = used + 9'd1;
        state_next = bal_pkg::S_DONE;
      end
      bal_pkg::S_DEL0: begin
        data_next = rdata;
        if ({1'b0, i} + 10'd1 < {1'b0, used}) begin
          rd_idx     = i + 9'd1;
          state_next = bal_pkg::S_DEL;
        end else begin
          used_next  = used - 9'd1;
          state_next = bal_pkg::S_DONE;
        end
      end
      bal_pkg::S_DEL: begin
        we     = 1'b1;
        wr_idx = i;
        wdata  = rdata;
        i_next = i + 9'd1;
        if ({1'b0, i} + 10'd2 < {1'b0, used}) begin
          rd_idx = i + 9'd2;
        end else begin
          used_next  = used - 9'd1;
          state_next = bal_pkg::S_DONE;
        end
      end
      bal_pkg::S_READ: begin
        data_next  = rdata;
        state_next = bal_pkg::S_DONE;
      end
      bal_pkg::S_SORT_I: begin
        hold_next = rdata;
        j_next    = i + 9'd1;
        if ({1'b0, i} + 10'd1 < {1'b0, used}) begin
          rd_idx     = i + 9'd1;
          state_next = bal_pkg::S_SORT_J;
        end else begin
          state_next = bal_pkg::S_DONE;
        end
      end
      bal_pkg::S_SORT_J: begin
        if ($signed(hold) > $signed(rdata)) begin
          we        = 1'b1;
          wr_idx    = j;
          wdata     = hold;
          hold_next = rdata;
        end
        j_next = j + 9'd1;
        if ({1'b0, j} + 10'd1 < {1'b0, used}) begin
          rd_idx = j + 9'd1;
        end else begin
          state_next = bal_pkg::S_SORT_W;
        end
      end
      bal_pkg::S_SORT_W: begin
        we     = 1'b1;
        wr_idx = i;
        wdata  = hold;
        i_next = i + 9'd1;
        if ({1'b0, i} + 10'd1 < {1'b0, used}) begin
          rd_idx     = i + 9'd1;
          state_next = bal_pkg::S_SORT_I;
        end else begin
          state_next = bal_pkg::S_DONE;
        end
      end
      bal_pkg::S_REV_A: begin
        hold_next  = rdata;
        rd_idx     = j;
        state_next = bal_pkg::S_REV_B;
      end
      bal_pkg::S_REV_B: begin
        we         = 1'b1;
        wr_idx     = i;
        wdata      = rdata;
        state_next = bal_pkg::S_REV_C;
      end
      bal_pkg::S_REV_C: begin
        we     = 1'b1;
        wr_idx = j;
        wdata  = hold;
        i_next = i + 9'd1;
        j_next = j - 9'd1;
        if ({1'b0, i} + 10'd1 < {1'b0, j} - 10'd1) begin
          rd_idx     = i + 9'd1;
          state_next = bal_pkg::S_REV_A;
        end else begin
          state_next = bal_pkg::S_DONE;
        end
      end
      bal_pkg::S_DONE: begin
        if (out_free) begin
          state_next = bal_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bal_pkg::S_IDLE;
      end
    endcase
  end

endmodule
